// ===== src/orthonormal_contact_basis_macros.svh =====
// ----------------------------------------------------------------------------
// Orthonormal contact basis: assertion macros
// Shared property wrappers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ORTHONORMAL_CONTACT_BASIS_MACROS_SVH
`define ORTHONORMAL_CONTACT_BASIS_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define OCB_ASSERT_HOLD(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ocb assertion failed");
// next-cycle implication
`define OCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ocb assertion failed");
`else
`define OCB_ASSERT_HOLD(label, clk, rst, ante, cons)
`define OCB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ocb_pkg.sv =====
// ----------------------------------------------------------------------------
// ocb_pkg
// Shared constants, types and helpers of the orthonormal contact basis.
// ----------------------------------------------------------------------------
package ocb_pkg;

   localparam int FRAC_BITS = 14;
   localparam int SQ_STEPS  = 16;   // two radicand bits per step, 32-bit radicand
   localparam int DV_STEPS  = 16;   // one quotient bit per step
   localparam int MID_DEPTH = 4;
   localparam int MID_PTR_W = $clog2(MID_DEPTH);
   localparam int NSTAGE    = SQ_STEPS + DV_STEPS + 3;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               use_x;
      logic [31:0]        d;
   } front_item_type;

   typedef struct packed {
      logic signed [15:0] tangent_a_x;
      logic signed [15:0] tangent_a_y;
      logic signed [15:0] tangent_a_z;
      logic signed [15:0] tangent_b_x;
      logic signed [15:0] tangent_b_y;
      logic signed [15:0] tangent_b_z;
      logic               degenerate;
   } rsp_item_type;

   // magnitude of a 16-bit signed value; -32768 maps to 32768
   function automatic logic [15:0] mag16(input logic signed [15:0] v);
      logic [15:0] m;
      m = v[15] ? 16'(~v + 16'd1) : 16'(v);
      return m;
   endfunction

endpackage

// ===== src/orthonormal_contact_basis.sv =====
// Throughput: one normal per cycle while no stall holds the flow; the back pipeline
// is fully pipelined (16 root steps, 16 divide steps, multiply and round), one step per stage.
// A full result queue stalls the whole back pipeline; the mid queue then fills.
// Reset (synchronous, active high) empties all queues and pipeline valid bits.
// ----------------------------------------------------------------------------
// orthonormal_contact_basis
// Completes a unit contact normal to an orthonormal basis in Q2.14 fixed point.
// ----------------------------------------------------------------------------
`include "orthonormal_contact_basis_macros.svh"

module orthonormal_contact_basis
   import ocb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request beats
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   // response beats
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_tangent_a_x,
   output logic signed [15:0] rsp_tangent_a_y,
   output logic signed [15:0] rsp_tangent_a_z,
   output logic signed [15:0] rsp_tangent_b_x,
   output logic signed [15:0] rsp_tangent_b_y,
   output logic signed [15:0] rsp_tangent_b_z,
   output logic               rsp_degenerate
);

   // front -> mid queue
   logic           mq_push, mq_full, mq_pop, mq_empty;
   front_item_type mq_wdata, mq_rdata;
   rsp_item_type   rsp_data;

   // Front: branch choice (|x| > |y|) and the two squares, one register stage.
   ocb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .nx     (req_normal_x),
      .ny     (req_normal_y),
      .nz     (req_normal_z),
      .full   (full),
      .q_push (mq_push),
      .q_data (mq_wdata),
      .q_full (mq_full)
   );

   // Decouples the front from stalls in the back.
   ocb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (mq_push),
      .wdata (mq_wdata),
      .full  (mq_full),
      .pop   (mq_pop),
      .rdata (mq_rdata),
      .empty (mq_empty)
   );

   // Back: integer root, rounding divides, cross product, result queue.
   ocb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (mq_empty),
      .q_data    (mq_rdata),
      .q_pop     (mq_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data)
   );

   assign rsp_tangent_a_x = rsp_data.tangent_a_x;
   assign rsp_tangent_a_y = rsp_data.tangent_a_y;
   assign rsp_tangent_a_z = rsp_data.tangent_a_z;
   assign rsp_tangent_b_x = rsp_data.tangent_b_x;
   assign rsp_tangent_b_y = rsp_data.tangent_b_y;
   assign rsp_tangent_b_z = rsp_data.tangent_b_z;
   assign rsp_degenerate  = rsp_data.degenerate;

   // a degenerate beat carries all-zero tangents
   `OCB_ASSERT_HOLD(a_deg_zero, clock, reset, !empty && rsp_degenerate, rsp_tangent_a_x == 16'sd0 && rsp_tangent_a_y == 16'sd0 && rsp_tangent_a_z == 16'sd0 && rsp_tangent_b_x == 16'sd0 && rsp_tangent_b_y == 16'sd0 && rsp_tangent_b_z == 16'sd0)
   // one of the first two tangent components is always zero
   `OCB_ASSERT_HOLD(a_branch_zero, clock, reset, !empty, rsp_tangent_a_x == 16'sd0 || rsp_tangent_a_y == 16'sd0)
   // reset leaves no result waiting
   `OCB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty)

endmodule

// ===== src/ocb_front.sv =====
// ----------------------------------------------------------------------------
// ocb_front
// Takes in normals, picks the branch and squares the two components.
// ----------------------------------------------------------------------------
module ocb_front
   import ocb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic signed [15:0]  nx,
   input  logic signed [15:0]  ny,
   input  logic signed [15:0]  nz,
   output logic                full,
   output logic                q_push,
   output front_item_type      q_data,
   input  logic                q_full
);

   logic               valid_ff, valid_in;
   logic               adv;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic               use_x_ff, use_x_in;
   logic signed [31:0] sq_t_ff, sq_o_ff;
   logic signed [15:0] other;

   assign adv      = !valid_ff || !q_full;
   assign full     = !adv;
   assign use_x_in = mag16(nx) > mag16(ny);   // tie goes to the y branch
   assign other    = use_x_in ? nx : ny;
   assign valid_in = adv ? push : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv) begin
         nx_ff    <= nx;
         ny_ff    <= ny;
         nz_ff    <= nz;
         use_x_ff <= use_x_in;
         sq_t_ff  <= nz * nz;
         sq_o_ff  <= other * other;
      end
   end

   assign q_push       = valid_ff && !q_full;
   assign q_data.nx    = nx_ff;
   assign q_data.ny    = ny_ff;
   assign q_data.nz    = nz_ff;
   assign q_data.use_x = use_x_ff;
   assign q_data.d     = 32'(sq_t_ff) + 32'(sq_o_ff);

endmodule

// ===== src/ocb_queue.sv =====
// ----------------------------------------------------------------------------
// ocb_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module ocb_queue
   import ocb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  front_item_type wdata,
   output logic           full,
   input  logic           pop,
   output front_item_type rdata,
   output logic           empty
);

   front_item_type         mem_ff [MID_DEPTH];
   logic [MID_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [MID_PTR_W:0]     cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full    = cnt_ff == (MID_PTR_W+1)'(MID_DEPTH);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ===== src/ocb_back.sv =====
// ----------------------------------------------------------------------------
// ocb_back
// Square root, two dividers and cross product as one stalling pipeline,
// followed by a two-beat result queue.
// ----------------------------------------------------------------------------
module ocb_back
   import ocb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  front_item_type q_data,
   output logic           q_pop,
   input  logic           rsp_pop,
   output logic           rsp_empty,
   output rsp_item_type   rsp_data
);

   typedef struct packed {
      logic signed [15:0] nx, ny, nz;
      logic               use_x;
      logic               deg;
      logic [31:0]        rem;
      logic [31:0]        res;
   } sq_item_type;

   typedef struct packed {
      logic signed [15:0] nx, ny, nz;
      logic               use_x;
      logic               deg;
      logic [16:0]        dvs;
      logic [30:0]        rem_a, rem_b;
      logic [15:0]        q_a, q_b;
      logic               neg_a, neg_b;
   } dv_item_type;

   typedef struct packed {
      logic               deg;
      logic signed [15:0] ax, ay, az;
      logic signed [31:0] p_yaz, p_zay, p_zax, p_xaz, p_xay, p_yax;
   } mu_item_type;

   function automatic sq_item_type sq_step(input sq_item_type s, input int k);
      sq_item_type o;
      logic [31:0] bitv;
      logic [32:0] trial;
      o     = s;
      bitv  = 32'd1 << (30 - 2*k);
      trial = {1'b0, s.res} + {1'b0, bitv};
      if ({1'b0, s.rem} >= trial) begin
         o.rem = s.rem - trial[31:0];
         o.res = (s.res >> 1) + bitv;
      end else begin
         o.res = s.res >> 1;
      end
      return o;
   endfunction

   function automatic dv_item_type dv_step(input dv_item_type s, input int i);
      dv_item_type o;
      logic [32:0] sh;
      o  = s;
      sh = {16'd0, s.dvs} << i;
      if ({2'b0, s.rem_a} >= sh) begin
         o.rem_a = 31'({2'b0, s.rem_a} - sh);
         o.q_a   = s.q_a | (16'd1 << i);
      end
      if ({2'b0, s.rem_b} >= sh) begin
         o.rem_b = 31'({2'b0, s.rem_b} - sh);
         o.q_b   = s.q_b | (16'd1 << i);
      end
      return o;
   endfunction

   function automatic logic signed [15:0] tan_val(input logic [15:0] q, input logic neg);
      logic signed [15:0] v;
      if (neg) begin
         v = q[15] ? 16'sh8000 : -$signed(q);
      end else begin
         v = q[15] ? 16'sh7fff : $signed(q);
      end
      return v;
   endfunction

   // round half up to FRAC_BITS and saturate
   function automatic logic signed [15:0] rescale(input logic signed [32:0] p);
      logic signed [32:0] t;
      logic signed [32:0] q;
      logic signed [15:0] v;
      t = p + (33'sd1 <<< (FRAC_BITS - 1));
      q = t >>> FRAC_BITS;
      if (q > 33'sd32767) v = 16'sh7fff;
      else if (q < -33'sd32768) v = 16'sh8000;
      else v = q[15:0];
      return v;
   endfunction

   logic                adv;
   logic [NSTAGE-1:0]   vld_ff, vld_in;
   sq_item_type         sq_src [SQ_STEPS];
   sq_item_type         sq_in  [SQ_STEPS];
   sq_item_type         sq_ff  [SQ_STEPS];
   dv_item_type         pr_in, pr_ff;
   dv_item_type         dv_src [DV_STEPS];
   dv_item_type         dv_in  [DV_STEPS];
   dv_item_type         dv_ff  [DV_STEPS];
   mu_item_type         mu_in, mu_ff;
   rsp_item_type        fin_in, fin_ff;
   sq_item_type         entry;
   sq_item_type         sq_last;
   dv_item_type         dv_last;
   logic [15:0]         r;
   logic [15:0]         mag_a, mag_b;
   logic signed [15:0]  a_a, a_b;

   // result queue
   rsp_item_type        oq_ff [2];
   logic                oq_wr_ff, oq_rd_ff;
   logic [1:0]          oq_cnt_ff, oq_cnt_in;
   logic                oq_full, oq_push, oq_pop;

   assign oq_full = oq_cnt_ff == 2'd2;
   assign adv     = !(vld_ff[NSTAGE-1] && oq_full);
   assign q_pop   = adv && !q_empty;
   assign oq_push = adv && vld_ff[NSTAGE-1];
   assign oq_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      vld_in = adv ? {vld_ff[NSTAGE-2:0], !q_empty} : vld_ff;
   end

   // square root
   always_comb begin
      entry.nx    = q_data.nx;
      entry.ny    = q_data.ny;
      entry.nz    = q_data.nz;
      entry.use_x = q_data.use_x;
      entry.deg   = q_data.d == '0;
      entry.rem   = q_data.d;
      entry.res   = '0;
      sq_src[0]   = entry;
      for (int k = 1; k < SQ_STEPS; k++) sq_src[k] = sq_ff[k-1];
      for (int k = 0; k < SQ_STEPS; k++) sq_in[k] = sq_step(sq_src[k], k);
   end

   // divider setup: numerator 2*|c|*2^F + r, divisor 2*r
   always_comb begin
      sq_last     = sq_ff[SQ_STEPS-1];
      r           = sq_last.res[15:0];
      mag_a       = mag16(sq_last.nz);
      mag_b       = sq_last.use_x ? mag16(sq_last.nx) : mag16(sq_last.ny);
      pr_in.nx    = sq_last.nx;
      pr_in.ny    = sq_last.ny;
      pr_in.nz    = sq_last.nz;
      pr_in.use_x = sq_last.use_x;
      pr_in.deg   = sq_last.deg;
      pr_in.dvs   = {r, 1'b0};
      pr_in.rem_a = {mag_a, 15'd0} + {15'd0, r};
      pr_in.rem_b = {mag_b, 15'd0} + {15'd0, r};
      pr_in.q_a   = '0;
      pr_in.q_b   = '0;
      pr_in.neg_a = sq_last.use_x ? sq_last.nz[15] : (sq_last.nz > 16'sd0);
      pr_in.neg_b = sq_last.use_x ? (sq_last.nx > 16'sd0) : sq_last.ny[15];
   end

   // restoring division, both lanes share the divisor
   always_comb begin
      dv_src[0] = pr_ff;
      for (int j = 1; j < DV_STEPS; j++) dv_src[j] = dv_ff[j-1];
      for (int j = 0; j < DV_STEPS; j++) dv_in[j] = dv_step(dv_src[j], DV_STEPS - 1 - j);
   end

   // first tangent and cross-product terms
   always_comb begin
      dv_last     = dv_ff[DV_STEPS-1];
      a_a         = tan_val(dv_last.q_a, dv_last.neg_a);
      a_b         = tan_val(dv_last.q_b, dv_last.neg_b);
      mu_in.deg   = dv_last.deg;
      mu_in.ax    = dv_last.use_x ? a_a : 16'sd0;
      mu_in.ay    = dv_last.use_x ? 16'sd0 : a_a;
      mu_in.az    = a_b;
      mu_in.p_yaz = dv_last.ny * mu_in.az;
      mu_in.p_zay = dv_last.nz * mu_in.ay;
      mu_in.p_zax = dv_last.nz * mu_in.ax;
      mu_in.p_xaz = dv_last.nx * mu_in.az;
      mu_in.p_xay = dv_last.nx * mu_in.ay;
      mu_in.p_yax = dv_last.ny * mu_in.ax;
   end

   always_comb begin
      fin_in.degenerate  = mu_ff.deg;
      fin_in.tangent_a_x = mu_ff.ax;
      fin_in.tangent_a_y = mu_ff.ay;
      fin_in.tangent_a_z = mu_ff.az;
      fin_in.tangent_b_x = rescale(33'(mu_ff.p_yaz) - 33'(mu_ff.p_zay));
      fin_in.tangent_b_y = rescale(33'(mu_ff.p_zax) - 33'(mu_ff.p_xaz));
      fin_in.tangent_b_z = rescale(33'(mu_ff.p_xay) - 33'(mu_ff.p_yax));
      if (mu_ff.deg) begin
         fin_in.tangent_a_x = '0;
         fin_in.tangent_a_y = '0;
         fin_in.tangent_a_z = '0;
         fin_in.tangent_b_x = '0;
         fin_in.tangent_b_y = '0;
         fin_in.tangent_b_z = '0;
      end
   end

   always_comb begin
      oq_cnt_in = oq_cnt_ff;
      if (oq_push && !oq_pop) oq_cnt_in = oq_cnt_ff + 2'd1;
      if (oq_pop && !oq_push) oq_cnt_in = oq_cnt_ff - 2'd1;
   end

   assign rsp_empty = oq_cnt_ff == 2'd0;
   assign rsp_data  = oq_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         vld_ff    <= vld_in;
         oq_cnt_ff <= oq_cnt_in;
         if (oq_push) oq_wr_ff <= !oq_wr_ff;
         if (oq_pop)  oq_rd_ff <= !oq_rd_ff;
      end
      if (adv) begin
         for (int k = 0; k < SQ_STEPS; k++) sq_ff[k] <= sq_in[k];
         pr_ff <= pr_in;
         for (int j = 0; j < DV_STEPS; j++) dv_ff[j] <= dv_in[j];
         mu_ff  <= mu_in;
         fin_ff <= fin_in;
      end
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= fin_ff;
      end
   end

endmodule

// ===== tb/sv/tb_orthonormal_contact_basis.sv =====
// ----------------------------------------------------------------------------
// tb_orthonormal_contact_basis
// Drives contact normals into the basis block and checks each tangent pair
// against a bit-accurate fixed-point predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_orthonormal_contact_basis
   import ocb_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // tangent predictor plus in-order store of expected beats
   class basis_scoreboard;
      rsp_item_type tangent_q[$];
      int errors = 0;
      int n_checked = 0;
      int n_degenerate = 0;
      int n_x_branch = 0;

      function automatic longint root_floor(longint d);
         longint res, bit_v;
         res = 0;
         bit_v = 64'sd1 << 62;
         while (bit_v > d) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (d >= res + bit_v) begin
               d = d - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return res;
      endfunction

      function automatic logic signed [15:0] clamp16(longint v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return 16'sh8000;
         return 16'(v);
      endfunction

      // round(c / r) in Q2.14, half away from zero
      function automatic logic signed [15:0] unit_scale(longint c, longint r);
         longint num, q;
         num = (c < 0 ? -c : c) << FRAC_BITS;
         q = (2 * num + r) / (2 * r);
         return clamp16(c < 0 ? -q : q);
      endfunction

      // product sum to Q2.14, half up (arithmetic shift floors)
      function automatic logic signed [15:0] round_prod(longint p);
         return clamp16((p + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
      endfunction

      function void note_normal(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
         rsp_item_type e;
         longint nx, ny, nz, oth, d, r;
         bit use_x;
         nx = x; ny = y; nz = z;
         e = '0;
         use_x = (nx < 0 ? -nx : nx) > (ny < 0 ? -ny : ny);
         oth = use_x ? nx : ny;
         d = nz * nz + oth * oth;
         if (d == 0) begin
            e.degenerate = 1'b1;
            n_degenerate++;
         end else begin
            r = root_floor(d);
            if (use_x) begin
               n_x_branch++;
               e.tangent_a_x = unit_scale(nz, r);
               e.tangent_a_z = unit_scale(-nx, r);
            end else begin
               e.tangent_a_y = unit_scale(-nz, r);
               e.tangent_a_z = unit_scale(ny, r);
            end
            e.tangent_b_x = round_prod(ny * e.tangent_a_z - nz * e.tangent_a_y);
            e.tangent_b_y = round_prod(nz * e.tangent_a_x - nx * e.tangent_a_z);
            e.tangent_b_z = round_prod(nx * e.tangent_a_y - ny * e.tangent_a_x);
         end
         tangent_q.push_back(e);
      endfunction

      function void check_beat(rsp_item_type got);
         rsp_item_type e;
         if (tangent_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            errors++;
            return;
         end
         e = tangent_q.pop_front();
         n_checked++;
         if (got.tangent_a_x !== e.tangent_a_x)
            $display("%0t: tangent_a_x exp %0d got %0d", $time, e.tangent_a_x, got.tangent_a_x);
         if (got.tangent_a_y !== e.tangent_a_y)
            $display("%0t: tangent_a_y exp %0d got %0d", $time, e.tangent_a_y, got.tangent_a_y);
         if (got.tangent_a_z !== e.tangent_a_z)
            $display("%0t: tangent_a_z exp %0d got %0d", $time, e.tangent_a_z, got.tangent_a_z);
         if (got.tangent_b_x !== e.tangent_b_x)
            $display("%0t: tangent_b_x exp %0d got %0d", $time, e.tangent_b_x, got.tangent_b_x);
         if (got.tangent_b_y !== e.tangent_b_y)
            $display("%0t: tangent_b_y exp %0d got %0d", $time, e.tangent_b_y, got.tangent_b_y);
         if (got.tangent_b_z !== e.tangent_b_z)
            $display("%0t: tangent_b_z exp %0d got %0d", $time, e.tangent_b_z, got.tangent_b_z);
         if (got.degenerate !== e.degenerate)
            $display("%0t: degenerate exp %0b got %0b", $time, e.degenerate, got.degenerate);
         if (got !== e) errors++;
      endfunction
   endclass

   logic clock, reset, push, full, empty, pop;
   logic signed [15:0] req_normal_x, req_normal_y, req_normal_z;
   logic signed [15:0] rsp_tangent_a_x, rsp_tangent_a_y, rsp_tangent_a_z;
   logic signed [15:0] rsp_tangent_b_x, rsp_tangent_b_y, rsp_tangent_b_z;
   logic rsp_degenerate;
   rsp_item_type rsp;
   basis_scoreboard sb;

   bit calm = 0;        // last part of the run: no idling on either side
   bit hold_rx = 0;     // long receiver hold-off to fill the block

   orthonormal_contact_basis DUT (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_normal_x(req_normal_x), .req_normal_y(req_normal_y),
      .req_normal_z(req_normal_z),
      .empty(empty), .pop(pop),
      .rsp_tangent_a_x(rsp_tangent_a_x), .rsp_tangent_a_y(rsp_tangent_a_y),
      .rsp_tangent_a_z(rsp_tangent_a_z), .rsp_tangent_b_x(rsp_tangent_b_x),
      .rsp_tangent_b_y(rsp_tangent_b_y), .rsp_tangent_b_z(rsp_tangent_b_z),
      .rsp_degenerate(rsp_degenerate)
   );

   assign rsp = {rsp_tangent_a_x, rsp_tangent_a_y, rsp_tangent_a_z,
                 rsp_tangent_b_x, rsp_tangent_b_y, rsp_tangent_b_z, rsp_degenerate};

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // beat monitors: sample at the edge, before any nonblocking updates land
   always @(posedge clock) begin
      if (!reset && push && !full) sb.note_normal(req_normal_x, req_normal_y, req_normal_z);
      if (!reset && pop && !empty) sb.check_beat(rsp);
   end

   // offer one normal and hold it until accepted
   task automatic send_normal(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_normal_x <= x;
      req_normal_y <= y;
      req_normal_z <= z;
      push <= 1'b1;
      do @(posedge clock); while (full);
   endtask

   // random component: mostly unit range, some full 16-bit, some near zero
   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(0, 9))
         0, 1, 2: return 16'($urandom);
         3:       return 16'($signed($urandom_range(0, 8)) - 4);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // receiver: random stall bursts, one long hold-off, none near the end
   initial begin
      pop = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rx) begin
            pop <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rx = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      logic signed [15:0] v, w;
      sb = new();
      push = 1'b0;
      req_normal_x = '0;
      req_normal_y = '0;
      req_normal_z = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // axes, both signs, zero normal, ties, field extremes
      send_normal(16384, 0, 0);
      send_normal(-16384, 0, 0);
      send_normal(0, 16384, 0);
      send_normal(0, -16384, 0);
      send_normal(0, 0, 16384);
      send_normal(0, 0, -16384);
      send_normal(0, 0, 0);                     // zero denominator
      send_normal(0, 5, 0);                     // y branch, z zero, still fine
      send_normal(11585, 11585, 0);             // tie, y formula
      send_normal(-11585, 11585, 0);
      send_normal(9459, -9459, 9459);
      send_normal(16'sh8000, 16'sh8000, 16'sh8000);
      send_normal(16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_normal(16'sh8000, 0, 16'sh8000);
      send_normal(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_normal(16'sh8000, 1, 0);
      send_normal(1, 0, 0);
      send_normal(-1, 0, 1);
      send_normal(16384, 1, 16'sh8000);
      send_normal(16'shffff, 16'sh7fff, 16'shffff);

      for (int i = 0; i < 1600; i++) begin
         if (i == 300) hold_rx = 1;
         if (i == 1400) calm = 1;
         if ($urandom_range(0, 9) == 0) begin
            v = rand_comp();           // forced ties and zero-denominator cases
            w = $urandom_range(0, 1) ? v : -v;
            send_normal(v, w, $urandom_range(0, 1) ? 16'sd0 : rand_comp());
         end else begin
            send_normal(rand_comp(), rand_comp(), rand_comp());
         end
      end
      push <= 1'b0;

      while (sb.tangent_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("checked %0d tangent pairs: %0d x-branch, %0d degenerate",
               sb.n_checked, sb.n_x_branch, sb.n_degenerate);
      $display("random stalls on both sides plus a long hold-off with input backpressure");
      if (sb.errors == 0)
         $display("[orthonormal_contact_basis] OK");
      else
         $display("[orthonormal_contact_basis] ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout waiting for result beats");
      $display("[orthonormal_contact_basis] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/ocb_pkg.sv
src/ocb_front.sv
src/ocb_queue.sv
src/ocb_back.sv
src/orthonormal_contact_basis.sv
tb/sv/tb_orthonormal_contact_basis.sv
